// File: design/jspi_pkg.sv
// shared types and character constants for the json stream pretty indenter
package jspi_pkg;

   localparam int TAB_W = 6;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   typedef struct packed {
      logic [7:0] in_char;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       run_last;
      logic       message_done;
   } rsp_type;

   // one classified input word, expanded later by the back end
   typedef struct packed {
      logic [7:0]       chr;
      logic [TAB_W-1:0] tabs;
      logic             brk_before;
      logic             brk_after;
      logic             add_space;
      logic             msg_end;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } cmd_wr_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHAR  = 6'b000010,
      ST_SPACE = 6'b000100,
      ST_CR    = 6'b001000,
      ST_LF    = 6'b010000,
      ST_TAB   = 6'b100000
   } back_state_type;

endpackage

// File: design/jspi_front.sv
// front end: parser state and classification of each input word
module jspi_front #(
   parameter int MAX_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  jspi_pkg::req_type   req_data,
   input  logic                q_full,
   output jspi_pkg::cmd_wr_type wr
);
   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

   logic               inside_ff, inside_in;
   logic               escape_ff, escape_in;
   logic               comma_ff, comma_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               accept;
   logic [7:0]         c;
   jspi_pkg::cmd_type  cmd;

   assign accept = req_push && !q_full;
   assign c      = req_data.in_char;

   always_comb begin
      inside_in      = inside_ff;
      escape_in      = escape_ff;
      comma_in       = 1'b0;
      depth_in       = depth_ff;
      cmd.chr        = c;
      cmd.tabs       = jspi_pkg::TAB_W'(depth_ff);
      cmd.brk_before = 1'b0;
      cmd.brk_after  = 1'b0;
      cmd.add_space  = 1'b0;
      cmd.msg_end    = req_data.message_end;
      if (inside_ff) begin
         if (escape_ff) begin
            escape_in = 1'b0;
         end else if (c == jspi_pkg::CH_BSLASH) begin
            escape_in = 1'b1;
         end else if (c == jspi_pkg::CH_QUOTE) begin
            inside_in = 1'b0;
         end
      end else begin
         case (c)
            jspi_pkg::CH_QUOTE: begin
               inside_in      = 1'b1;
               cmd.brk_before = comma_ff;
            end
            jspi_pkg::CH_COLON: begin
               cmd.add_space = 1'b1;
            end
            jspi_pkg::CH_COMMA: begin
               comma_in = 1'b1;
            end
            jspi_pkg::CH_LBRACE, jspi_pkg::CH_LBRACK: begin
               if (depth_ff < DEPTH_W'(MAX_DEPTH)) depth_in = depth_ff + 1'b1;
               cmd.brk_after = 1'b1;
               cmd.tabs      = jspi_pkg::TAB_W'(depth_in);
            end
            jspi_pkg::CH_RBRACE, jspi_pkg::CH_RBRACK: begin
               if (depth_ff != '0) depth_in = depth_ff - 1'b1;
               cmd.brk_before = 1'b1;
               cmd.tabs       = jspi_pkg::TAB_W'(depth_in);
            end
            default: begin
            end
         endcase
      end
      if (req_data.message_end) begin
         inside_in = 1'b0;
         escape_in = 1'b0;
         comma_in  = 1'b0;
         depth_in  = '0;
      end
   end

   assign wr.push = accept;
   assign wr.cmd  = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         escape_ff <= 1'b0;
         comma_ff  <= 1'b0;
         depth_ff  <= '0;
      end else if (accept) begin
         inside_ff <= inside_in;
         escape_ff <= escape_in;
         comma_ff  <= comma_in;
         depth_ff  <= depth_in;
      end
   end

endmodule

// File: design/jspi_cmd_queue.sv
// two-entry queue of classified words between front and back end
module jspi_cmd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  jspi_pkg::cmd_wr_type wr,
   output logic                 full,
   output logic                 valid,
   output jspi_pkg::cmd_type    rd_cmd,
   input  logic                 pop
);
   jspi_pkg::cmd_type mem_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              do_push;
   logic              do_pop;

   assign full    = count_ff == 2'd2;
   assign valid   = count_ff != 2'd0;
   assign do_push = wr.push && !full;
   assign do_pop  = pop && valid;
   assign rd_cmd  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= wr.cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= ~rd_ptr_ff;
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// File: design/jspi_back.sv
// back end: expands each classified word into its output byte run
module jspi_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  jspi_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output jspi_pkg::rsp_type rsp_data
);
   jspi_pkg::back_state_type state_ff, state_in, step_next;
   jspi_pkg::cmd_type        cmd_ff;
   logic [jspi_pkg::TAB_W-1:0] tab_cnt_ff;
   logic                     out_valid_ff;
   jspi_pkg::rsp_type        out_ff;
   logic                     adv;
   logic                     emit;
   logic                     last;
   logic                     load;
   logic [7:0]               byte_val;

   assign adv  = !out_valid_ff || rsp_pop;
   assign emit = adv && (state_ff != jspi_pkg::ST_IDLE);

   always_comb begin
      byte_val  = 8'h00;
      last      = 1'b0;
      step_next = jspi_pkg::ST_IDLE;
      unique case (state_ff)
         jspi_pkg::ST_IDLE: begin
         end
         jspi_pkg::ST_CHAR: begin
            byte_val = cmd_ff.chr;
            if (cmd_ff.add_space)      step_next = jspi_pkg::ST_SPACE;
            else if (cmd_ff.brk_after) step_next = jspi_pkg::ST_CR;
            else                       last      = 1'b1;
         end
         jspi_pkg::ST_SPACE: begin
            byte_val = jspi_pkg::CH_SPACE;
            last     = 1'b1;
         end
         jspi_pkg::ST_CR: begin
            byte_val  = jspi_pkg::CH_CR;
            step_next = jspi_pkg::ST_LF;
         end
         jspi_pkg::ST_LF: begin
            byte_val = jspi_pkg::CH_LF;
            if (cmd_ff.tabs != '0)     step_next = jspi_pkg::ST_TAB;
            else if (cmd_ff.brk_after) last      = 1'b1;
            else                       step_next = jspi_pkg::ST_CHAR;
         end
         jspi_pkg::ST_TAB: begin
            byte_val = jspi_pkg::CH_TAB;
            if (tab_cnt_ff != jspi_pkg::TAB_W'(1)) step_next = jspi_pkg::ST_TAB;
            else if (cmd_ff.brk_after)             last      = 1'b1;
            else                                   step_next = jspi_pkg::ST_CHAR;
         end
         default: begin
         end
      endcase
   end

   assign load  = q_valid && ((state_ff == jspi_pkg::ST_IDLE) || (emit && last));
   assign q_pop = load;

   always_comb begin
      if (load) begin
         state_in = q_cmd.brk_before ? jspi_pkg::ST_CR : jspi_pkg::ST_CHAR;
      end else if (emit) begin
         state_in = last ? jspi_pkg::ST_IDLE : step_next;
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff     <= q_cmd;
         tab_cnt_ff <= q_cmd.tabs;
      end else if (emit && state_ff == jspi_pkg::ST_TAB) begin
         tab_cnt_ff <= tab_cnt_ff - 1'b1;
      end
      if (emit) begin
         out_ff.out_char     <= byte_val;
         out_ff.run_last     <= last;
         out_ff.message_done <= last && cmd_ff.msg_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jspi_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit)         out_valid_ff <= 1'b1;
         else if (rsp_pop) out_valid_ff <= 1'b0;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// File: design/json_stream_pretty_indenter.sv
// top level of the json stream pretty indenter
// usage:
//   input words enter as a queue push: req_data is taken at a clock edge with
//   req_push high and req_full low. each word carries one text byte and a
//   message_end mark on the final byte of a message.
//   output bytes leave as a queue pop: rsp_data holds the oldest byte while
//   rsp_empty is low and is consumed at an edge with rsp_pop high.
//   run_last marks the final byte produced by one input word, message_done
//   the final byte of a message.
// flow and throughput:
//   a word is classified as it is taken and written to the queue at that edge;
//   the back end loads it from the queue and its run of 1 to MAX_DEPTH + 3
//   bytes leaves at one byte per cycle while the receiver pops, so the
//   back-end sequencer sets the rate: plain bytes and string contents give
//   1 byte, colons 2, brackets and comma line breaks 3 + indent depth.
//   first byte passes through the queue, the back-end state and output registers.
// reset and stalls:
//   synchronous reset clears parser state, the word queue and the output
//   register. when the receiver stops popping, the output register holds,
//   the sequencer stops, the two-word queue fills and req_full rises.
module json_stream_pretty_indenter #(
   parameter int MAX_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  jspi_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output jspi_pkg::rsp_type rsp_data
);
   // classified word from the front end into the queue
   jspi_pkg::cmd_wr_type wr;
   jspi_pkg::cmd_type    q_cmd;
   logic                 q_full;
   logic                 q_valid;
   logic                 q_pop;

   // front end keeps string, escape, comma and depth state
   jspi_front #(
      .MAX_DEPTH(MAX_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .wr       (wr)
   );

   // decouples the parser from the byte expander
   jspi_cmd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .full   (q_full),
      .valid  (q_valid),
      .rd_cmd (q_cmd),
      .pop    (q_pop)
   );

   // expands each word into line breaks, tabs, spaces and the byte itself
   jspi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // input is refused only while the queue is full
   assign req_full = q_full;

endmodule
